@@ hdl/dac_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and functions of the decimal amount codec
package dac_pkg;

   localparam int WordWidth  = 64;
   localparam int DigitWidth = 4;
   localparam int NumCells   = WordWidth / DigitWidth;

   localparam logic [DigitWidth-1:0] ExpLimit = 4'd9;

   typedef enum logic [0:0] {
      ACT_COMPRESS   = 1'b0,
      ACT_DECOMPRESS = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CDIV,
      ST_NINE,
      ST_DIGIT,
      ST_SCALE,
      ST_ADD,
      ST_DDIV10,
      ST_DDIV9,
      ST_WIDEN,
      ST_DONE
   } state_type;

   // token and partial remainder handed from one cell to the next lower one
   typedef struct packed {
      logic                  token;
      logic [DigitWidth-1:0] rem;
   } link_type;

   typedef struct packed {
      logic                  done;
      logic [DigitWidth-1:0] rem;
   } div_status_type;

   typedef struct packed {
      logic [DigitWidth-1:0] quo;
      logic [DigitWidth-1:0] rem;
   } digit_div_type;

   typedef struct packed {
      logic [WordWidth-1:0] prod;
      logic                 ovf;
   } scaled_type;

   // one long-division digit step, {rem, nib} < 160, by 9 or 10 via reciprocal
   function automatic digit_div_type digit_div(input logic [DigitWidth-1:0] rem,
                                               input logic [DigitWidth-1:0] nib,
                                               input logic by_nine);
      logic [2*DigitWidth-1:0] v;
      logic [15:0]             prod;
      logic [DigitWidth-1:0]   q;
      logic [2*DigitWidth-1:0] back;
      digit_div_type           r;
      v = {rem, nib};
      if (by_nine) begin
         prod = 16'(v) * 16'd57;
         q    = prod[12:9];
         back = 8'(q) * 8'd9;
      end else begin
         prod = 16'(v) * 16'd205;
         q    = prod[14:11];
         back = 8'(q) * 8'd10;
      end
      r.quo = q;
      r.rem = DigitWidth'(v - back);
      return r;
   endfunction

   // v * 10 wrapped, with a flag when the true product leaves the word
   function automatic scaled_type times_ten(input logic [WordWidth-1:0] v);
      logic [WordWidth+3:0] p;
      scaled_type           r;
      p      = ({4'b0, v} << 3) + ({4'b0, v} << 1);
      r.prod = p[WordWidth-1:0];
      r.ovf  = |p[WordWidth+3:WordWidth];
      return r;
   endfunction

endpackage

@@ hdl/dac_cell.sv @@
`timescale 1ns / 1ps
// one digit cell of the divider row: holds a nibble, passes the remainder down
module dac_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [dac_pkg::DigitWidth-1:0] load_nib,
   input  logic                         by_nine,
   input  dac_pkg::link_type            link_in,
   output dac_pkg::link_type            link_out,
   output logic [dac_pkg::DigitWidth-1:0] nib_out
);

   logic [dac_pkg::DigitWidth-1:0] nib_ff, nib_in;
   logic [dac_pkg::DigitWidth-1:0] rem_ff, rem_in;
   logic                           token_ff, token_in;
   dac_pkg::digit_div_type         step;

   assign step = dac_pkg::digit_div(link_in.rem, nib_ff, by_nine);

   always_comb begin
      nib_in   = nib_ff;
      rem_in   = rem_ff;
      token_in = link_in.token & ~load;
      if (load) begin
         nib_in = load_nib;
      end else if (link_in.token) begin
         nib_in = step.quo;
         rem_in = step.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
      end
      nib_ff <= nib_in;
      rem_ff <= rem_in;
   end

   assign link_out = {token_ff, rem_ff};
   assign nib_out  = nib_ff;

endmodule

@@ hdl/dac_divider.sv @@
`timescale 1ns / 1ps
// divide-by-9-or-10 unit built as a row of digit cells, one digit per cycle
module dac_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dac_pkg::WordWidth-1:0] operand,
   input  logic                          by_nine,
   output logic [dac_pkg::WordWidth-1:0] quotient,
   output dac_pkg::div_status_type       status
);

   logic              go_ff, go_in;
   logic              by_nine_ff, by_nine_in;
   dac_pkg::link_type links [dac_pkg::NumCells+1];

   always_comb begin
      go_in      = start;
      by_nine_in = start ? by_nine : by_nine_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
      end
      by_nine_ff <= by_nine_in;
   end

   // top cell starts with a zero remainder
   assign links[dac_pkg::NumCells] = {go_ff, {dac_pkg::DigitWidth{1'b0}}};

   for (genvar g = 0; g < dac_pkg::NumCells; g++) begin : g_cell
      dac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (start),
         .load_nib (operand[g*dac_pkg::DigitWidth +: dac_pkg::DigitWidth]),
         .by_nine  (by_nine_ff),
         .link_in  (links[g+1]),
         .link_out (links[g]),
         .nib_out  (quotient[g*dac_pkg::DigitWidth +: dac_pkg::DigitWidth])
      );
   end

   assign status.done = links[0].token;
   assign status.rem  = links[0].rem;

endmodule

@@ hdl/decimal_amount_codec.sv @@
`timescale 1ns / 1ps
// top level of the decimal amount codec: sequencer, accumulator and output register
//
//   channel  | ports                         | word
//   ---------+-------------------------------+----------------------------------
//   input    | req_tvalid/tready/tdata/tuser | tdata: value, tuser: action
//   result   | rsp_tvalid/tready/tdata/tuser | tdata: result, tuser: overflow
//
// compress: divide by ten until a nonzero remainder or nine zeros, then times nine, add
// digit - 1, times ten, add exponent + 1; at nine zeros: quotient - 1, times ten, add 10
// decompress: divide by ten, then by nine unless the exponent is nine; zero input: done
// one word in flight; idle again on the edge that loads rsp, so the next word is taken
// on the following edge; a result still held in rsp stalls the sequencer in its done state
// reset is synchronous and clears the sequencer and rsp_tvalid
module decimal_amount_codec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dac_pkg::WordWidth-1:0] req_tdata,   // [63:0] value
   input  logic                          req_tuser,   // [0] action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dac_pkg::WordWidth-1:0] rsp_tdata,   // [63:0] result
   output logic                          rsp_tuser    // [0] overflow
);

   dac_pkg::state_type              state_ff, state_in;
   dac_pkg::action_type             mode_ff, mode_in;
   logic [dac_pkg::WordWidth-1:0]   acc_ff, acc_in;
   logic [dac_pkg::DigitWidth-1:0]  exp_ff, exp_in;
   logic [dac_pkg::DigitWidth-1:0]  digit_ff, digit_in;
   logic                            ovf_ff, ovf_in;
   logic                            out_valid_ff, out_valid_in;
   logic [dac_pkg::WordWidth-1:0]   out_data_ff, out_data_in;
   logic                            out_ovf_ff, out_ovf_in;

   logic                            div_start;
   logic [dac_pkg::WordWidth-1:0]   div_operand;
   logic                            div_by_nine;
   logic [dac_pkg::WordWidth-1:0]   div_quotient;
   dac_pkg::div_status_type         div_status;

   dac_pkg::scaled_type             scaled;
   logic [dac_pkg::WordWidth:0]     add_sum;
   logic [dac_pkg::DigitWidth-1:0]  exp_next;

   dac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .operand  (div_operand),
      .by_nine  (div_by_nine),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign scaled   = dac_pkg::times_ten(acc_ff);
   assign add_sum  = {1'b0, acc_ff} + (dac_pkg::WordWidth+1)'({1'b0, exp_ff} + 5'd1);
   assign exp_next = exp_ff + 4'd1;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      digit_in     = digit_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_data_in  = out_data_ff;
      out_ovf_in   = out_ovf_ff;
      div_start    = 1'b0;
      div_operand  = div_quotient;
      div_by_nine  = 1'b0;
      req_tready   = (state_ff == dac_pkg::ST_IDLE);

      unique case (state_ff)
         dac_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = dac_pkg::action_type'(req_tuser);
               exp_in  = '0;
               ovf_in  = 1'b0;
               if (req_tdata == '0) begin
                  acc_in   = '0;
                  state_in = dac_pkg::ST_DONE;
               end else if (dac_pkg::action_type'(req_tuser) == dac_pkg::ACT_COMPRESS) begin
                  div_start   = 1'b1;
                  div_operand = req_tdata;
                  state_in    = dac_pkg::ST_CDIV;
               end else begin
                  div_start   = 1'b1;
                  div_operand = req_tdata - 64'd1;
                  state_in    = dac_pkg::ST_DDIV10;
               end
            end
         end
         dac_pkg::ST_CDIV: begin
            if (div_status.done) begin
               if (div_status.rem == '0) begin
                  exp_in = exp_next;
                  if (exp_next == dac_pkg::ExpLimit) begin
                     acc_in   = div_quotient - 64'd1;
                     state_in = dac_pkg::ST_SCALE;
                  end else begin
                     div_start = 1'b1;
                  end
               end else begin
                  acc_in   = div_quotient;
                  digit_in = div_status.rem;
                  state_in = dac_pkg::ST_NINE;
               end
            end
         end
         dac_pkg::ST_NINE: begin
            acc_in   = {acc_ff[dac_pkg::WordWidth-4:0], 3'b000} + acc_ff;
            state_in = dac_pkg::ST_DIGIT;
         end
         dac_pkg::ST_DIGIT: begin
            if (mode_ff == dac_pkg::ACT_COMPRESS) begin
               acc_in = acc_ff + 64'(digit_ff - 4'd1);
            end else begin
               acc_in = acc_ff + 64'({1'b0, digit_ff} + 5'd1);
            end
            state_in = dac_pkg::ST_SCALE;
         end
         dac_pkg::ST_SCALE: begin
            if (mode_ff == dac_pkg::ACT_COMPRESS) begin
               acc_in   = scaled.prod;
               ovf_in   = ovf_ff | scaled.ovf;
               state_in = dac_pkg::ST_ADD;
            end else if (exp_ff == '0) begin
               state_in = dac_pkg::ST_DONE;
            end else begin
               acc_in = scaled.prod;
               ovf_in = ovf_ff | scaled.ovf;
               exp_in = exp_ff - 4'd1;
            end
         end
         dac_pkg::ST_ADD: begin
            acc_in   = add_sum[dac_pkg::WordWidth-1:0];
            ovf_in   = ovf_ff | add_sum[dac_pkg::WordWidth];
            state_in = dac_pkg::ST_DONE;
         end
         dac_pkg::ST_DDIV10: begin
            if (div_status.done) begin
               exp_in = div_status.rem;
               if (div_status.rem != dac_pkg::ExpLimit) begin
                  div_start   = 1'b1;
                  div_by_nine = 1'b1;
                  state_in    = dac_pkg::ST_DDIV9;
               end else begin
                  acc_in   = div_quotient + 64'd1;
                  state_in = dac_pkg::ST_SCALE;
               end
            end
         end
         dac_pkg::ST_DDIV9: begin
            if (div_status.done) begin
               acc_in   = div_quotient;
               digit_in = div_status.rem;
               state_in = dac_pkg::ST_WIDEN;
            end
         end
         dac_pkg::ST_WIDEN: begin
            acc_in   = scaled.prod;
            state_in = dac_pkg::ST_DIGIT;
         end
         dac_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = acc_ff;
               out_ovf_in   = ovf_ff;
               state_in     = dac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dac_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dac_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff     <= mode_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      digit_ff    <= digit_in;
      ovf_ff      <= ovf_in;
      out_data_ff <= out_data_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

@@ hdl/dac_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the decimal amount codec and its bind
module dac_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [dac_pkg::WordWidth-1:0] rsp_tdata,
   input logic                          rsp_tuser
);

   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + 2'((req_tvalid & req_tready))
                              - 2'((rsp_tvalid & rsp_tready));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result word without an accepted input word");

   a_two_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_tready)
      else $error("input taken with a word in work and one waiting");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind decimal_amount_codec dac_checker u_dac_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the decimal amount codec: directed and random words, back-pressure
module testbench;

   typedef struct {
      logic [dac_pkg::WordWidth-1:0] result;
      logic                          overflow;
   } codec_word_type;

   localparam logic [dac_pkg::WordWidth-1:0] TenthOfMax = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
   localparam int DrainCycles = 250;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [dac_pkg::WordWidth-1:0] req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [dac_pkg::WordWidth-1:0] rsp_tdata;
   logic                          rsp_tuser;

   codec_word_type expected_words[$];
   int          fail_count       = 0;
   int          words_checked    = 0;
   int          compress_words   = 0;
   int          expand_words     = 0;
   int          overflow_results = 0;
   int          burst_left       = 0;
   int          hold_request     = 0;
   int          hold_left        = 0;
   int          stall_mode       = 0;
   int          stall_mode_left  = 0;
   int          stall_phase      = 0;
   logic [7:0]  stall_pattern    = 8'hFF;

   decimal_amount_codec DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("decimal_amount_codec regression: fail");
      $finish;
   end

   function automatic logic [dac_pkg::WordWidth-1:0] scale_by_ten(
         input logic [dac_pkg::WordWidth-1:0] v, inout logic ovf);
      if (v > TenthOfMax) ovf = 1'b1;
      return v * 64'd10;
   endfunction

   function automatic codec_word_type compress_amount(
         input logic [dac_pkg::WordWidth-1:0] amount);
      logic [dac_pkg::WordWidth-1:0] n;
      logic [dac_pkg::WordWidth-1:0] t;
      logic [dac_pkg::WordWidth-1:0] sum;
      int                            zeros;
      codec_word_type                r;
      r.result   = '0;
      r.overflow = 1'b0;
      if (amount == 0) return r;
      n     = amount;
      zeros = 0;
      while (n % 64'd10 == 0 && zeros < 9) begin
         n = n / 64'd10;
         zeros++;
      end
      if (zeros < 9) begin
         // fold the last nonzero digit into the quotient
         t   = (n / 64'd10) * 64'd9 + (n % 64'd10) - 64'd1;
         t   = scale_by_ten(t, r.overflow);
         sum = t + 64'(zeros + 1);
      end else begin
         t   = scale_by_ten(n - 64'd1, r.overflow);
         sum = t + 64'd10;
      end
      if (sum < t) r.overflow = 1'b1;
      r.result = sum;
      return r;
   endfunction

   function automatic codec_word_type expand_code(input logic [dac_pkg::WordWidth-1:0] code);
      logic [dac_pkg::WordWidth-1:0] x;
      logic [dac_pkg::WordWidth-1:0] n;
      int                            zeros;
      codec_word_type                r;
      r.result   = '0;
      r.overflow = 1'b0;
      if (code == 0) return r;
      x     = code - 64'd1;
      zeros = int'(x % 64'd10);
      x     = x / 64'd10;
      if (zeros < 9) n = (x / 64'd9) * 64'd10 + (x % 64'd9) + 64'd1;
      else           n = x + 64'd1;
      repeat (zeros) n = scale_by_ten(n, r.overflow);
      r.result = n;
      return r;
   endfunction

   function automatic logic [dac_pkg::WordWidth-1:0] rand_bits(input int width);
      logic [dac_pkg::WordWidth-1:0] v;
      v = {$urandom, $urandom};
      if (width < dac_pkg::WordWidth) v = v & ((64'd1 << width) - 64'd1);
      return v;
   endfunction

   function automatic logic [dac_pkg::WordWidth-1:0] ten_power(input int k);
      logic [dac_pkg::WordWidth-1:0] p;
      p = 64'd1;
      repeat (k) p = p * 64'd10;
      return p;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // result check first, then the new expectation, so a word never matches itself
   always @(posedge clock) begin : rsp_check
      codec_word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               note_failure($sformatf("unexpected word result=%h overflow=%b",
                                      rsp_tdata, rsp_tuser));
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (rsp_tuser) overflow_results++;
               if (rsp_tdata !== want.result || rsp_tuser !== want.overflow)
                  note_failure($sformatf("word %0d: expected result=%h overflow=%b, got %h %b",
                                         words_checked, want.result, want.overflow,
                                         rsp_tdata, rsp_tuser));
            end
         end
         if (req_tvalid && req_tready) begin
            if (dac_pkg::action_type'(req_tuser) == dac_pkg::ACT_COMPRESS) begin
               expected_words.push_back(compress_amount(req_tdata));
               compress_words++;
            end else begin
               expected_words.push_back(expand_code(req_tdata));
               expand_words++;
            end
         end
      end
   end

   // receiver: long hold on request, otherwise stretches of varying stall behavior
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 200);
            stall_pattern   = 8'($urandom) | 8'h01;
         end
         stall_mode_left--;
         stall_phase = (stall_phase + 1) % 8;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= stall_pattern[stall_phase];
         endcase
      end
   end

   task automatic offer_word(input dac_pkg::action_type act,
                             input logic [dac_pkg::WordWidth-1:0] amount);
      int gap_cycles;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap_cycles > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= amount;
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic test_zero_inputs();
      offer_word(dac_pkg::ACT_COMPRESS, 64'd0);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd0);
   endtask

   task automatic test_compress_directed();
      offer_word(dac_pkg::ACT_COMPRESS, 64'd1);
      offer_word(dac_pkg::ACT_COMPRESS, 64'd9);
      offer_word(dac_pkg::ACT_COMPRESS, 64'd10);
      offer_word(dac_pkg::ACT_COMPRESS, 64'd19);
      offer_word(dac_pkg::ACT_COMPRESS, 64'd1_000_000_000);
      offer_word(dac_pkg::ACT_COMPRESS, 64'd120_000_000_000);
      offer_word(dac_pkg::ACT_COMPRESS, 64'd10_000_000_000_000_000_000);
      offer_word(dac_pkg::ACT_COMPRESS, 64'hFFFF_FFFF_FFFF_FFFF);
      offer_word(dac_pkg::ACT_COMPRESS, 64'h8000_0000_0000_0000);
   endtask

   task automatic test_expand_directed();
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd1);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd2);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd9);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd10);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd11);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd10_000_000_000_009);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'hFFFF_FFFF_FFFF_FFFF);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'h7FFF_FFFF_FFFF_FFFF);
      offer_word(dac_pkg::ACT_DECOMPRESS, 64'd184_467_440_737_095_520);
   endtask

   task automatic test_random_traffic(input int count);
      int sel;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            // amounts with a spread of trailing zeros
            offer_word(dac_pkg::ACT_COMPRESS, rand_bits($urandom_range(1, 64))
                                              * ten_power($urandom_range(0, 12)));
         end else if (sel < 85) begin
            // codes with every exponent and mantissas from 1 to 60 bits wide
            offer_word(dac_pkg::ACT_DECOMPRESS, rand_bits($urandom_range(1, 60)) * 64'd10
                                                + 64'($urandom_range(0, 9)) + 64'd1);
         end else begin
            offer_word(dac_pkg::action_type'($urandom_range(0, 1)),
                       ($urandom_range(0, 19) == 0) ? 64'd0 : rand_bits(dac_pkg::WordWidth));
         end
      end
   endtask

   task automatic test_input_backpressure();
      hold_request = 1200;
      repeat (40)
         offer_word(dac_pkg::action_type'($urandom_range(0, 1)),
                    rand_bits($urandom_range(1, 64)));
   endtask

   initial begin : main
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_inputs();
      test_compress_directed();
      test_expand_directed();
      test_random_traffic(1800);
      test_input_backpressure();
      req_tvalid <= 1'b0;

      waited = 0;
      while (expected_words.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (expected_words.size() != 0)
         note_failure($sformatf("%0d words never came back", expected_words.size()));

      $display("checked %0d words (%0d compress, %0d expand), %0d with overflow",
               words_checked, compress_words, expand_words, overflow_results);
      $display("%0d failures, including a long receiver hold with input back-pressure",
               fail_count);
      if (fail_count == 0) begin
         $display("decimal_amount_codec regression: pass");
      end else begin
         $display("decimal_amount_codec regression: fail");
      end
      $finish;
   end

endmodule
